// ----- rtl/rau_pkg.sv -----
`timescale 1ns / 1ps
package rau_pkg;

  localparam int W  = 32;      // operand word width
  localparam int DW = 2 * W;   // cross product width

  localparam logic [2:0] CMD_NORM = 3'd0;
  localparam logic [2:0] CMD_ADD  = 3'd1;
  localparam logic [2:0] CMD_SUB  = 3'd2;
  localparam logic [2:0] CMD_MUL  = 3'd3;
  localparam logic [2:0] CMD_DIV  = 3'd4;
  localparam logic [2:0] CMD_CMP  = 3'd5;

  // one queued beat, tagged by the front end
  typedef struct packed {
    logic [2:0]   cmd;
    logic [W-1:0] a_num;
    logic [W-1:0] a_den;
    logic [W-1:0] b_num;
    logic [W-2:0] b_den;
    logic         a_zero;
    logic         b_zero;
  } item_t;

  typedef struct packed {
    logic          start;
    logic [DW-1:0] x;
    logic [DW-1:0] y;
  } red_req_t;

  typedef struct packed {
    logic          done;
    logic [DW-1:0] qx;
    logic [DW-1:0] qy;
  } red_rsp_t;

endpackage

// ----- rtl/rau_front.sv -----
`timescale 1ns / 1ps
module rau_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          cmd,
  input  logic [rau_pkg::W-1:0] a_num,
  input  logic [rau_pkg::W-1:0] a_den,
  input  logic [rau_pkg::W-1:0] b_num,
  input  logic [rau_pkg::W-2:0] b_den,
  output logic                q_valid,
  output rau_pkg::item_t      q_item,
  input  logic                q_pop
);

  rau_pkg::item_t q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign busy    = (count == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (count != 2'd0);
  assign q_item  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr].cmd    <= cmd;
      q[wr_ptr].a_num  <= a_num;
      q[wr_ptr].a_den  <= a_den;
      q[wr_ptr].b_num  <= b_num;
      q[wr_ptr].b_den  <= b_den;
      q[wr_ptr].a_zero <= (a_den == '0);
      q[wr_ptr].b_zero <= (b_den == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// ----- rtl/rau_reduce.sv -----
`timescale 1ns / 1ps
// binary gcd, then bit-serial exact division of both parts by the gcd
module rau_reduce (
  input  logic              clk,
  input  logic              rst,
  input  rau_pkg::red_req_t req,
  output rau_pkg::red_rsp_t rsp
);

  localparam logic [1:0] R_IDLE = 2'd0;
  localparam logic [1:0] R_GCD  = 2'd1;
  localparam logic [1:0] R_DIV  = 2'd2;

  logic [1:0]              st;
  logic [rau_pkg::DW-1:0]  u, v, g, xs, ys, rx, ry;
  logic [5:0]              k;
  logic [5:0]              cnt;
  logic                    done;
  logic [rau_pkg::DW:0]    tx, ty;
  logic                    bx, by;

  assign tx = {rx, xs[rau_pkg::DW-1]};
  assign ty = {ry, ys[rau_pkg::DW-1]};
  assign bx = (tx >= {1'b0, g});
  assign by = (ty >= {1'b0, g});

  assign rsp.done = done;
  assign rsp.qx   = xs;
  assign rsp.qy   = ys;

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= R_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st)
        R_IDLE: begin
          if (req.start) begin
            u  <= req.x;
            v  <= req.y;
            xs <= req.x;
            ys <= req.y;
            k  <= '0;
            st <= R_GCD;
          end
        end
        R_GCD: begin
          if (u == '0 || v == '0 || u == v) begin
            if (u == '0 && v == '0) g <= {{(rau_pkg::DW-1){1'b0}}, 1'b1};
            else if (u == '0)       g <= v;
            else if (v == '0)       g <= u;
            else                    g <= u << k;
            rx  <= '0;
            ry  <= '0;
            cnt <= '1;
            st  <= R_DIV;
          end else if (!u[0] && !v[0]) begin
            u <= u >> 1;
            v <= v >> 1;
            k <= k + 6'd1;
          end else if (!u[0]) begin
            u <= u >> 1;
          end else if (!v[0]) begin
            v <= v >> 1;
          end else if (u > v) begin
            u <= u - v;
          end else begin
            v <= v - u;
          end
        end
        R_DIV: begin
          // quotient bits shift into the dividend registers
          rx <= bx ? tx[rau_pkg::DW-1:0] - g : tx[rau_pkg::DW-1:0];
          ry <= by ? ty[rau_pkg::DW-1:0] - g : ty[rau_pkg::DW-1:0];
          xs <= {xs[rau_pkg::DW-2:0], bx};
          ys <= {ys[rau_pkg::DW-2:0], by};
          cnt <= cnt - 6'd1;
          if (cnt == '0) begin
            done <= 1'b1;
            st   <= R_IDLE;
          end
        end
        default: st <= R_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/rau_core.sv -----
`timescale 1ns / 1ps
module rau_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  rau_pkg::item_t        q_item,
  output logic                  q_pop,
  output rau_pkg::red_req_t     red_req,
  input  rau_pkg::red_rsp_t     red_rsp,
  output logic                  done,
  output logic [rau_pkg::W-1:0] res_num,
  output logic [rau_pkg::W-2:0] res_den,
  output logic                  error,
  output logic                  overflow,
  output logic                  less,
  output logic                  greater,
  output logic                  equal
);

  localparam int W  = rau_pkg::W;
  localparam int DW = rau_pkg::DW;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RA   = 4'd1;
  localparam logic [3:0] S_RB   = 4'd2;
  localparam logic [3:0] S_M1   = 4'd3;
  localparam logic [3:0] S_M2   = 4'd4;
  localparam logic [3:0] S_M3   = 4'd5;
  localparam logic [3:0] S_M4   = 4'd6;
  localparam logic [3:0] S_COMB = 4'd7;
  localparam logic [3:0] S_RR   = 4'd8;
  localparam logic [3:0] S_CHK  = 4'd9;

  logic [3:0]    st;
  logic [2:0]    cmd;
  logic          sa, sb, rs, err, have;
  logic [W-1:0]  ma, mda, mb, mdb;
  logic [DW-1:0] p1, p2, p3, p4, rn_mag, rd_mag;
  logic [DW-1:0] red_x, red_y;
  logic          red_go;

  logic [W-1:0]  an_mag, ad_eff, ad_mag, bn_mag;
  logic [W-2:0]  bd_eff;
  logic [W-1:0]  m_a, m_b;
  logic [DW-1:0] prod;
  logic [DW:0]   v1, v2, sum, dif, smag, dmag;
  logic          num_ok, den_ok;

  assign q_pop = (st == S_IDLE) && q_valid;

  assign red_req.start = red_go;
  assign red_req.x     = red_x;
  assign red_req.y     = red_y;

  // operand magnitudes, zero denominators replaced by one
  assign ad_eff = q_item.a_zero ? {{(W-1){1'b0}}, 1'b1} : q_item.a_den;
  assign bd_eff = q_item.b_zero ? {{(W-2){1'b0}}, 1'b1} : q_item.b_den;
  assign an_mag = q_item.a_num[W-1] ? -q_item.a_num : q_item.a_num;
  assign ad_mag = ad_eff[W-1] ? -ad_eff : ad_eff;
  assign bn_mag = q_item.b_num[W-1] ? -q_item.b_num : q_item.b_num;

  always_comb begin
    m_a = ma;
    m_b = mdb;
    case (st)
      S_M2:    begin m_a = mb; m_b = mda; end
      S_M3:    begin m_a = ma; m_b = mb;  end
      S_M4:    begin m_a = mda; m_b = mdb; end
      default: begin m_a = ma; m_b = mdb; end
    endcase
  end
  assign prod = {{W{1'b0}}, m_a} * {{W{1'b0}}, m_b};

  // signed cross products, one extra bit
  assign v1   = sa ? (~{1'b0, p1} + 1'b1) : {1'b0, p1};
  assign v2   = sb ? (~{1'b0, p2} + 1'b1) : {1'b0, p2};
  assign sum  = v1 + v2;
  assign dif  = v1 - v2;
  assign smag = sum[DW] ? -sum : sum;
  assign dmag = dif[DW] ? -dif : dif;

  assign den_ok = (rd_mag[DW-1:W-1] == '0);
  assign num_ok = rs ? (rn_mag <= {{(DW-W){1'b0}}, 1'b1, {(W-1){1'b0}}})
                     : (rn_mag[DW-1:W-1] == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= S_IDLE;
      red_go <= 1'b0;
      done   <= 1'b0;
    end else begin
      red_go <= 1'b0;
      done   <= 1'b0;
      unique case (st)
        S_IDLE: begin
          if (q_valid) begin
            cmd    <= q_item.cmd;
            err    <= q_item.a_zero || q_item.b_zero;
            sa     <= q_item.a_num[W-1] ^ ad_eff[W-1];
            sb     <= q_item.b_num[W-1];
            mb     <= bn_mag;
            mdb    <= {1'b0, bd_eff};
            red_x  <= {{W{1'b0}}, an_mag};
            red_y  <= {{W{1'b0}}, ad_mag};
            red_go <= 1'b1;
            st     <= S_RA;
          end
        end
        S_RA: begin
          if (red_rsp.done) begin
            ma     <= red_rsp.qx[W-1:0];
            mda    <= red_rsp.qy[W-1:0];
            red_x  <= {{W{1'b0}}, mb};
            red_y  <= {{W{1'b0}}, mdb};
            red_go <= 1'b1;
            st     <= S_RB;
          end
        end
        S_RB: begin
          if (red_rsp.done) begin
            mb  <= red_rsp.qx[W-1:0];
            mdb <= red_rsp.qy[W-1:0];
            st  <= S_M1;
          end
        end
        S_M1: begin p1 <= prod; st <= S_M2; end
        S_M2: begin p2 <= prod; st <= S_M3; end
        S_M3: begin p3 <= prod; st <= S_M4; end
        S_M4: begin p4 <= prod; st <= S_COMB; end
        S_COMB: begin
          less    <= 1'b0;
          greater <= 1'b0;
          equal   <= 1'b0;
          have    <= 1'b0;
          rs      <= 1'b0;
          rn_mag  <= '0;
          rd_mag  <= {{(DW-1){1'b0}}, 1'b1};
          st      <= S_CHK;
          case (cmd)
            rau_pkg::CMD_NORM: begin
              rs     <= sa;
              rn_mag <= {{W{1'b0}}, ma};
              rd_mag <= {{W{1'b0}}, mda};
              have   <= 1'b1;
            end
            rau_pkg::CMD_ADD: begin
              rs     <= sum[DW];
              red_x  <= smag[DW-1:0];
              red_y  <= p4;
              red_go <= 1'b1;
              have   <= 1'b1;
              st     <= S_RR;
            end
            rau_pkg::CMD_SUB: begin
              rs     <= dif[DW];
              red_x  <= dmag[DW-1:0];
              red_y  <= p4;
              red_go <= 1'b1;
              have   <= 1'b1;
              st     <= S_RR;
            end
            rau_pkg::CMD_MUL: begin
              rs     <= sa ^ sb;
              red_x  <= p3;
              red_y  <= p4;
              red_go <= 1'b1;
              have   <= 1'b1;
              st     <= S_RR;
            end
            rau_pkg::CMD_DIV: begin
              if (mb == '0) begin
                err <= 1'b1;
              end else begin
                rs     <= sa ^ sb;
                red_x  <= p1;
                red_y  <= p2;
                red_go <= 1'b1;
                have   <= 1'b1;
                st     <= S_RR;
              end
            end
            rau_pkg::CMD_CMP: begin
              less    <= $signed(v1) <  $signed(v2);
              greater <= $signed(v1) >  $signed(v2);
              equal   <= (v1 == v2);
            end
            default: ;
          endcase
        end
        S_RR: begin
          if (red_rsp.done) begin
            rn_mag <= red_rsp.qx;
            rd_mag <= red_rsp.qy;
            st     <= S_CHK;
          end
        end
        S_CHK: begin
          done  <= 1'b1;
          error <= err;
          if (have && num_ok && den_ok) begin
            res_num  <= rs ? -rn_mag[W-1:0] : rn_mag[W-1:0];
            res_den  <= rd_mag[W-2:0];
            overflow <= 1'b0;
          end else begin
            res_num  <= '0;
            res_den  <= {{(W-2){1'b0}}, 1'b1};
            overflow <= have;
          end
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/rational_arithmetic_unit.sv -----
`timescale 1ns / 1ps
// Rational arithmetic unit. Raise start with a command and fractions a, b;
// the beat is taken on an edge where busy is low. A two-beat queue sits in
// front, so busy only rises when two commands are waiting. Each command
// gives one result, shown for exactly one cycle with done high; there is
// no backpressure, so capture it on that cycle. Results come back in
// command order. A command runs three passes through a shared reduce
// unit (normalize a, normalize b, reduce the result), each a binary gcd
// loop followed by a one-bit-per-cycle divider, plus four multiply steps
// on one 32x32 multiplier. Compare and normalize skip the third pass.
// Zero denominators set error and count as 1; divide by a zero fraction
// gives 0/1 with error. A result that does not fit gives 0/1 with overflow.
module rational_arithmetic_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            cmd,
  input  logic [rau_pkg::W-1:0] a_num,
  input  logic [rau_pkg::W-1:0] a_den,
  input  logic [rau_pkg::W-1:0] b_num,
  input  logic [rau_pkg::W-2:0] b_den,
  output logic                  done,
  output logic [rau_pkg::W-1:0] res_num,
  output logic [rau_pkg::W-2:0] res_den,
  output logic                  error,
  output logic                  overflow,
  output logic                  less,
  output logic                  greater,
  output logic                  equal
);

  logic              q_valid;
  logic              q_pop;
  rau_pkg::item_t    q_item;
  rau_pkg::red_req_t red_req;
  rau_pkg::red_rsp_t red_rsp;

  // front end: accept and tag beats, buffer two
  rau_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .cmd     (cmd),
    .a_num   (a_num),
    .a_den   (a_den),
    .b_num   (b_num),
    .b_den   (b_den),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  // back end sequencer: products, sums, range check, result register
  rau_core u_core (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .red_req  (red_req),
    .red_rsp  (red_rsp),
    .done     (done),
    .res_num  (res_num),
    .res_den  (res_den),
    .error    (error),
    .overflow (overflow),
    .less     (less),
    .greater  (greater),
    .equal    (equal)
  );

  // shared gcd + exact divide
  rau_reduce u_reduce (
    .clk (clk),
    .rst (rst),
    .req (red_req),
    .rsp (red_rsp)
  );

endmodule

// ----- rtl/rau_checker.sv -----
`timescale 1ns / 1ps
module rau_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  done,
  input logic [rau_pkg::W-1:0] res_num,
  input logic [rau_pkg::W-2:0] res_den,
  input logic                  overflow,
  input logic                  less,
  input logic                  greater,
  input logic                  equal
);

  a_done_gap: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("back-to-back result beats");

  a_ovf_zero: assert property (@(posedge clk) disable iff (rst)
    done && overflow |-> res_num == '0 && res_den == 1)
    else $error("overflow result not 0/1");

  a_cmp_onehot: assert property (@(posedge clk) disable iff (rst)
    done && (less || greater || equal) |-> $onehot({less, greater, equal}))
    else $error("compare flags not one-hot");

  a_cmp_no_ovf: assert property (@(posedge clk) disable iff (rst)
    done && (less || greater || equal) |-> !overflow && res_den == 1)
    else $error("compare result carries overflow or fraction");

  a_den_nz: assert property (@(posedge clk) disable iff (rst)
    done |-> res_den != '0) else $error("zero result denominator");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk      (clk),
  .rst      (rst),
  .done     (done),
  .res_num  (res_num),
  .res_den  (res_den),
  .overflow (overflow),
  .less     (less),
  .greater  (greater),
  .equal    (equal)
);
